FILE: hw/rtl/bwts_pkg.sv
// bwts_pkg: widths, codes and shared types of the bilinear wrap texture sampler
// no dependencies; used by the channel interfaces and the top level
package bwts_pkg;

   // texture geometry
   localparam int MAX_SIDE    = 256;
   localparam int SIDE_W      = 9;                 // side register, 0..MAX_SIDE
   localparam int COORD_W     = 8;                 // texel column or row
   localparam int ADDR_W      = 16;                // texel store address
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

   // coordinate fixed point
   localparam int COORD_IN_W = 32;
   localparam int FRAC_W     = 16;
   localparam int ONE_W      = FRAC_W + 1;

   // texel channels and blend widths
   localparam int NUM_CHAN  = 3;
   localparam int CHAN_W    = 16;
   localparam int TEXEL_W   = NUM_CHAN * CHAN_W;
   localparam int OUT_W     = 13;
   localparam int ONE_TEXEL = 4096;
   localparam int TOP_W     = CHAN_W + FRAC_W;     // one horizontal lerp
   localparam int ACC_W     = TOP_W + FRAC_W;      // full bilinear sum

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = CSR_IDX_W'(1);

   // request actions
   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_out_type;

endpackage

FILE: hw/rtl/bwts_if.sv
// bwts_req_if and bwts_rsp_if: valid/ready channels of the texture sampler
// depends on bwts_pkg for field widths
interface bwts_req_if;
   logic                               valid;
   logic                               ready;
   logic                               action;
   logic [bwts_pkg::ADDR_W-1:0]        texel_index;
   logic [bwts_pkg::CHAN_W-1:0]        texel_red;
   logic [bwts_pkg::CHAN_W-1:0]        texel_green;
   logic [bwts_pkg::CHAN_W-1:0]        texel_blue;
   logic signed [bwts_pkg::COORD_IN_W-1:0] coord_u;
   logic signed [bwts_pkg::COORD_IN_W-1:0] coord_v;

   modport source (output valid, action, texel_index, texel_red, texel_green, texel_blue,
                   coord_u, coord_v, input ready);
   modport sink (input valid, action, texel_index, texel_red, texel_green, texel_blue,
                 coord_u, coord_v, output ready);
endinterface

interface bwts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bwts_pkg::OUT_W-1:0] red;
   logic [bwts_pkg::OUT_W-1:0] green;
   logic [bwts_pkg::OUT_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: hw/rtl/bilinear_wrap_texture_sampler_top.sv
// bilinear_wrap_texture_sampler_top: texel store, address pipeline and bilinear blend
// depends on bwts_pkg, bwts_req_if, bwts_rsp_if and bwts_ram
//
//   channel   | direction | handshake        | content
//   ----------+-----------+------------------+--------------------------------------------
//   req_chan  | in        | valid/ready      | texel write or sample request
//   rsp_chan  | out       | valid/ready      | filtered red, green, blue (one per sample)
//   csr_*     | in        | write enable     | tex_width (index 0), tex_height (index 1)
//
// one request per cycle while ready is high; a sample result is valid once its request
// has passed stage 1, five more pipeline stages around the registered texel store read,
// then the result queue write
// writes land in the store from stage 3, in request order
// reset (synchronous, active high) clears the sizes, pipeline valids and result queue;
// the texel store holds garbage until written and needs no clearing
// an 8-entry result queue keeps taking requests while results wait; ready drops only
// when 8 samples are in flight or queued
module bilinear_wrap_texture_sampler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bwts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bwts_pkg::SIDE_W-1:0]    csr_wdata,
   bwts_req_if.sink                       req_chan,
   bwts_rsp_if.source                     rsp_chan
);

   localparam int SW = bwts_pkg::SIDE_W;
   localparam int CW = bwts_pkg::COORD_W;
   localparam int AW = bwts_pkg::ADDR_W;
   localparam int FW = bwts_pkg::FRAC_W;
   localparam int HW = bwts_pkg::CHAN_W;
   localparam int NC = bwts_pkg::NUM_CHAN;

   // ---------------------------------------------------------------------------------
   // configuration: sides saturate to the store's side length
   // ---------------------------------------------------------------------------------
   logic [SW-1:0] tex_width_ff, tex_width_in;
   logic [SW-1:0] tex_height_ff, tex_height_in;
   logic [SW-1:0] csr_side_sat;

   always_comb begin
      csr_side_sat  = (csr_wdata > SW'(bwts_pkg::MAX_SIDE)) ? SW'(bwts_pkg::MAX_SIDE)
                                                            : csr_wdata;
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      if (csr_we && csr_index == bwts_pkg::CSR_TEX_WIDTH) begin
         tex_width_in = csr_side_sat;
      end
      if (csr_we && csr_index == bwts_pkg::CSR_TEX_HEIGHT) begin
         tex_height_in = csr_side_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= '0;
         tex_height_ff <= '0;
      end else begin
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
      end
   end

   // side minus one, the largest column and row
   logic [SW-1:0] width_m1;
   logic [SW-1:0] height_m1;
   logic [CW-1:0] last_col;
   logic [CW-1:0] last_row;

   assign width_m1  = tex_width_ff - SW'(1);
   assign height_m1 = tex_height_ff - SW'(1);
   assign last_col  = width_m1[CW-1:0];
   assign last_row  = height_m1[CW-1:0];

   // ---------------------------------------------------------------------------------
   // request handshake and in-flight accounting
   // ---------------------------------------------------------------------------------
   logic                          req_take;
   logic                          rsp_take;
   logic [bwts_pkg::FIFO_CNT_W-1:0] pending_ff, pending_in;

   assign req_chan.ready = (pending_ff < bwts_pkg::FIFO_CNT_W'(bwts_pkg::FIFO_DEPTH));
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;

   // every sample owns a queue slot from request to response
   always_comb begin
      pending_in = pending_ff;
      if (req_take && req_chan.action == bwts_pkg::ACTION_SAMPLE) begin
         pending_in = pending_in + bwts_pkg::FIFO_CNT_W'(1);
      end
      if (rsp_take) begin
         pending_in = pending_in - bwts_pkg::FIFO_CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 1: capture request, wrap coordinates to their fraction, flip v
   // ---------------------------------------------------------------------------------
   logic                     s1_valid_ff;
   logic                     s1_sample_ff;
   logic [AW-1:0]            s1_index_ff;
   logic [bwts_pkg::TEXEL_W-1:0] s1_texel_ff;
   logic [FW-1:0]            s1_fu_ff;
   logic [bwts_pkg::ONE_W-1:0] s1_ofv_ff, s1_ofv_in;

   // one minus fv, 2^F when v has no fraction
   assign s1_ofv_in = (bwts_pkg::ONE_W'(1) << FW)
                      - {1'b0, req_chan.coord_v[FW-1:0]};

   // ---------------------------------------------------------------------------------
   // stage 2: scale by side minus one, split into integer and fraction
   // ---------------------------------------------------------------------------------
   logic [FW+CW-1:0]                 xq;
   logic [bwts_pkg::ONE_W+CW-1:0]    yq;
   logic                     s2_valid_ff;
   logic                     s2_sample_ff;
   logic [AW-1:0]            s2_index_ff;
   logic [bwts_pkg::TEXEL_W-1:0] s2_texel_ff;
   logic [CW-1:0]            s2_x0_ff, s2_y0_ff;
   logic [FW-1:0]            s2_tx_ff, s2_ty_ff;

   assign xq = s1_fu_ff * last_col;
   assign yq = s1_ofv_ff * last_row;

   // ---------------------------------------------------------------------------------
   // stage 3: far neighbour clamped to the last column or row, row bases
   // ---------------------------------------------------------------------------------
   logic [SW-1:0]            x0_inc, y0_inc;
   logic [CW-1:0]            x1_in, y1_in;
   logic [CW+SW-1:0]         row0_full, row1_full;
   logic                     s3_valid_ff;
   logic                     s3_sample_ff;
   logic [AW-1:0]            s3_index_ff;
   logic [bwts_pkg::TEXEL_W-1:0] s3_texel_ff;
   logic [CW-1:0]            s3_x0_ff, s3_x1_ff;
   logic [AW-1:0]            s3_row0_ff, s3_row1_ff;
   logic [FW-1:0]            s3_tx_ff, s3_ty_ff;

   assign x0_inc    = {1'b0, s2_x0_ff} + SW'(1);
   assign y0_inc    = {1'b0, s2_y0_ff} + SW'(1);
   assign x1_in     = (x0_inc < tex_width_ff) ? x0_inc[CW-1:0] : last_col;
   assign y1_in     = (y0_inc < tex_height_ff) ? y0_inc[CW-1:0] : last_row;
   assign row0_full = s2_y0_ff * tex_width_ff;
   assign row1_full = y1_in * tex_width_ff;

   // ---------------------------------------------------------------------------------
   // texel store: two copies with two read ports each, so all four neighbours
   // come out in the same cycle; writes go to both copies from stage 3, in order
   // with the sample reads issued there
   // ---------------------------------------------------------------------------------
   logic                         store_wr_en;
   logic [AW-1:0]                addr00, addr10, addr01, addr11;
   logic [bwts_pkg::TEXEL_W-1:0] texel00, texel10, texel01, texel11;

   assign store_wr_en = s3_valid_ff && !s3_sample_ff;
   assign addr00 = s3_row0_ff + {{(AW-CW){1'b0}}, s3_x0_ff};
   assign addr10 = s3_row0_ff + {{(AW-CW){1'b0}}, s3_x1_ff};
   assign addr01 = s3_row1_ff + {{(AW-CW){1'b0}}, s3_x0_ff};
   assign addr11 = s3_row1_ff + {{(AW-CW){1'b0}}, s3_x1_ff};

   // top row neighbours
   bwts_ram #(
      .WIDTH (bwts_pkg::TEXEL_W),
      .DEPTH (bwts_pkg::STORE_DEPTH)
   ) u_store_top (
      .clock     (clock),
      .wr_en     (store_wr_en),
      .wr_addr   (s3_index_ff),
      .wr_data   (s3_texel_ff),
      .rd_addr_a (addr00),
      .rd_addr_b (addr10),
      .rd_data_a (texel00),
      .rd_data_b (texel10)
   );

   // bottom row neighbours
   bwts_ram #(
      .WIDTH (bwts_pkg::TEXEL_W),
      .DEPTH (bwts_pkg::STORE_DEPTH)
   ) u_store_bot (
      .clock     (clock),
      .wr_en     (store_wr_en),
      .wr_addr   (s3_index_ff),
      .wr_data   (s3_texel_ff),
      .rd_addr_a (addr01),
      .rd_addr_b (addr11),
      .rd_data_a (texel01),
      .rd_data_b (texel11)
   );

   // stage 4 runs alongside the store read; only samples continue
   logic          s4_valid_ff;
   logic [FW-1:0] s4_tx_ff, s4_ty_ff;

   // ---------------------------------------------------------------------------------
   // stage 5: horizontal lerp, top = c00*2^F + (c10 - c00)*tx
   // ---------------------------------------------------------------------------------
   logic signed [HW:0]           dif_top [NC];
   logic signed [HW:0]           dif_bot [NC];
   logic signed [2*HW+1:0]       sum_top [NC];
   logic signed [2*HW+1:0]       sum_bot [NC];
   logic [bwts_pkg::TOP_W-1:0]   s5_top_ff [NC];
   logic [bwts_pkg::TOP_W-1:0]   s5_bot_ff [NC];
   logic                         s5_valid_ff;
   logic [FW-1:0]                s5_ty_ff;

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         dif_top[ch] = $signed({1'b0, texel10[(NC-1-ch)*HW +: HW]})
                     - $signed({1'b0, texel00[(NC-1-ch)*HW +: HW]});
         dif_bot[ch] = $signed({1'b0, texel11[(NC-1-ch)*HW +: HW]})
                     - $signed({1'b0, texel01[(NC-1-ch)*HW +: HW]});
         sum_top[ch] = $signed({2'b00, texel00[(NC-1-ch)*HW +: HW], {FW{1'b0}}})
                     + dif_top[ch] * $signed({1'b0, s4_tx_ff});
         sum_bot[ch] = $signed({2'b00, texel01[(NC-1-ch)*HW +: HW], {FW{1'b0}}})
                     + dif_bot[ch] * $signed({1'b0, s4_tx_ff});
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 6: vertical lerp, acc = top*2^F + (bottom - top)*ty
   // ---------------------------------------------------------------------------------
   logic signed [bwts_pkg::TOP_W:0]       dif_v [NC];
   logic signed [bwts_pkg::ACC_W+1:0]     sum_v [NC];
   logic [bwts_pkg::ACC_W-1:0]            s6_acc_ff [NC];
   logic                                  s6_valid_ff;

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         dif_v[ch] = $signed({1'b0, s5_bot_ff[ch]}) - $signed({1'b0, s5_top_ff[ch]});
         sum_v[ch] = $signed({2'b00, s5_top_ff[ch], {FW{1'b0}}})
                   + dif_v[ch] * $signed({1'b0, s5_ty_ff});
      end
   end

   // ---------------------------------------------------------------------------------
   // round half up, saturate to 1.0; an empty texture answers white
   // ---------------------------------------------------------------------------------
   logic [bwts_pkg::ACC_W:0]            rnd_sum [NC];
   logic [bwts_pkg::ACC_W-2*FW:0]       rnd_val [NC];
   logic [bwts_pkg::OUT_W-1:0]          chan_out [NC];
   logic                                tex_empty;
   bwts_pkg::rgb_out_type               push_data;

   assign tex_empty = (tex_width_ff == '0) || (tex_height_ff == '0);

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         rnd_sum[ch] = {1'b0, s6_acc_ff[ch]}
                     + ((bwts_pkg::ACC_W+1)'(1) << (2*FW-1));
         rnd_val[ch] = rnd_sum[ch][bwts_pkg::ACC_W:2*FW];
         if (tex_empty
             || rnd_val[ch] > (bwts_pkg::ACC_W-2*FW+1)'(bwts_pkg::ONE_TEXEL)) begin
            chan_out[ch] = bwts_pkg::OUT_W'(bwts_pkg::ONE_TEXEL);
         end else begin
            chan_out[ch] = rnd_val[ch][bwts_pkg::OUT_W-1:0];
         end
      end
      push_data.red   = chan_out[0];
      push_data.green = chan_out[1];
      push_data.blue  = chan_out[2];
   end

   // ---------------------------------------------------------------------------------
   // pipeline registers: valids reset, payload free running
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         s1_valid_ff <= req_take;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff && s3_sample_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         pending_ff  <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1
      s1_sample_ff <= (req_chan.action == bwts_pkg::ACTION_SAMPLE);
      s1_index_ff  <= req_chan.texel_index;
      s1_texel_ff  <= {req_chan.texel_red, req_chan.texel_green, req_chan.texel_blue};
      s1_fu_ff     <= req_chan.coord_u[FW-1:0];
      s1_ofv_ff    <= s1_ofv_in;
      // stage 2
      s2_sample_ff <= s1_sample_ff;
      s2_index_ff  <= s1_index_ff;
      s2_texel_ff  <= s1_texel_ff;
      s2_x0_ff     <= xq[FW +: CW];
      s2_tx_ff     <= xq[FW-1:0];
      s2_y0_ff     <= yq[FW +: CW];
      s2_ty_ff     <= yq[FW-1:0];
      // stage 3
      s3_sample_ff <= s2_sample_ff;
      s3_index_ff  <= s2_index_ff;
      s3_texel_ff  <= s2_texel_ff;
      s3_x0_ff     <= s2_x0_ff;
      s3_x1_ff     <= x1_in;
      s3_row0_ff   <= row0_full[AW-1:0];
      s3_row1_ff   <= row1_full[AW-1:0];
      s3_tx_ff     <= s2_tx_ff;
      s3_ty_ff     <= s2_ty_ff;
      // stage 4
      s4_tx_ff     <= s3_tx_ff;
      s4_ty_ff     <= s3_ty_ff;
      // stage 5
      s5_ty_ff     <= s4_ty_ff;
      for (int ch = 0; ch < NC; ch++) begin
         s5_top_ff[ch] <= sum_top[ch][bwts_pkg::TOP_W-1:0];
         s5_bot_ff[ch] <= sum_bot[ch][bwts_pkg::TOP_W-1:0];
         s6_acc_ff[ch] <= sum_v[ch][bwts_pkg::ACC_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // result queue: sized to every sample that can be pending, so it never overflows
   // ---------------------------------------------------------------------------------
   bwts_pkg::rgb_out_type                 fifo_ff [bwts_pkg::FIFO_DEPTH];
   logic [bwts_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bwts_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bwts_pkg::FIFO_CNT_W-1:0]       fifo_cnt_ff, fifo_cnt_in;
   logic                                  fifo_push;
   bwts_pkg::rgb_out_type                 fifo_head;

   assign fifo_push = s6_valid_ff;
   assign fifo_head = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in   = fifo_push ? wr_ptr_ff + bwts_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in   = rsp_take ? rd_ptr_ff + bwts_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (fifo_push) begin
         fifo_cnt_in = fifo_cnt_in + bwts_pkg::FIFO_CNT_W'(1);
      end
      if (rsp_take) begin
         fifo_cnt_in = fifo_cnt_in - bwts_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid = (fifo_cnt_ff != '0);
   assign rsp_chan.red   = fifo_head.red;
   assign rsp_chan.green = fifo_head.green;
   assign rsp_chan.blue  = fifo_head.blue;

`ifndef SYNTHESIS
   // every queued result is still counted as pending
   a_queue_within_pending: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= pending_ff)
      else $error("result queue holds more than pending samples");

   // a result never arrives at a full queue without a pop
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_cnt_ff < bwts_pkg::FIFO_CNT_W'(bwts_pkg::FIFO_DEPTH)) || rsp_take)
      else $error("result queue overflow");

   // a taken sample enters stage 1 as a sample
   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.action == bwts_pkg::ACTION_SAMPLE)
      |=> (s1_valid_ff && s1_sample_ff))
      else $error("sample request lost at stage 1");

   // a sample at the store read reaches the queue through stages 4, 5 and 6
   a_sample_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_sample_ff) |=> ##2 fifo_push)
      else $error("sample dropped between store read and queue");
`endif

endmodule

FILE: hw/rtl/bwts_ram.sv
// bwts_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies
module bwts_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
